[src/sha256_pkg.sv]
package sha256_pkg;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam int         QDEPTH    = 2;

    // request from front to back: one byte event
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_req;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[src/sha256_front.sv]
module sha256_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_valid,
    input  logic               i_is_last,
    input  logic               i_valid,
    output logic               o_stall,
    output sha256_pkg::t_req   o_req,
    output logic               o_req_valid,
    input  logic               i_req_pop
);

    sha256_pkg::t_req r_q [sha256_pkg::QDEPTH];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    // items with no byte and no last are dropped here
    assign o_stall     = (r_cnt == 2'(sha256_pkg::QDEPTH));
    assign w_push      = i_valid && !o_stall && (i_byte_valid || i_is_last);
    assign w_pop       = i_req_pop && (r_cnt != 2'd0);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{data: i_data_byte, valid: i_byte_valid, last: i_is_last};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

[src/sha256_back.sv]
module sha256_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha256_pkg::t_req i_req,
    input  logic             i_req_valid,
    output logic             o_req_pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word,
    output logic             o_length_error,
    output logic             o_valid,
    input  logic             i_stall
);

    sha256_pkg::t_state r_st, n_st;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [63:0] r_total;
    logic        r_ovf;
    logic [5:0]  r_rnd;
    logic        r_final;
    logic        r_second;
    logic        r_pad_head;
    logic [2:0]  r_oidx;

    logic        w_take, w_add, w_full_byte;
    logic [31:0] w_wt, w_s0, w_s1, w_t1, w_t2, w_e, w_a;
    logic [63:0] w_bits;
    logic [7:0]  w_pbyte;
    logic [5:0]  w_ppos;

    assign w_bits = {r_total[60:0], 3'b000};

    always_comb begin
        o_req_pop = (r_st == sha256_pkg::ST_FILL) && i_req_valid;
        o_valid   = (r_st == sha256_pkg::ST_EMIT);
    end

    assign w_take      = o_req_pop;
    assign w_add       = w_take && i_req.valid && (r_total != '1);
    assign w_full_byte = w_add && (r_fill == 6'd63);
    assign w_ppos      = w_add ? r_fill + 6'd1 : r_fill;

    // padding byte at current fill position
    always_comb begin
        if (r_pad_head) begin
            w_pbyte = sha256_pkg::PAD_BYTE;
        end else if (r_fill >= sha256_pkg::LEN_START && !r_second) begin
            w_pbyte = 8'h00;
        end else if (r_fill >= sha256_pkg::LEN_START) begin
            w_pbyte = w_bits[8 * (6'd63 - r_fill) +: 8];
        end else begin
            w_pbyte = 8'h00;
        end
    end

    // message schedule runs in the 16-word window
    assign w_wt = r_w[0];
    assign w_s0 = sha256_pkg::rotr(r_w[1], 7) ^ sha256_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1 = sha256_pkg::rotr(r_w[14], 17) ^ sha256_pkg::rotr(r_w[14], 19)
                ^ (r_w[14] >> 10);
    assign w_e  = r_v[4];
    assign w_a  = r_v[0];
    assign w_t1 = r_v[7] + (sha256_pkg::rotr(w_e, 6) ^ sha256_pkg::rotr(w_e, 11)
                ^ sha256_pkg::rotr(w_e, 25)) + ((w_e & r_v[5]) ^ (~w_e & r_v[6]))
                + sha256_pkg::K_TABLE[r_rnd] + w_wt;
    assign w_t2 = (sha256_pkg::rotr(w_a, 2) ^ sha256_pkg::rotr(w_a, 13)
                ^ sha256_pkg::rotr(w_a, 22)) + ((w_a & r_v[1]) ^ (w_a & r_v[2])
                ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_st = r_st;
        case (r_st)
            sha256_pkg::ST_FILL: begin
                if (w_full_byte) n_st = sha256_pkg::ST_ROUND;
                else if (w_take && i_req.last) n_st = sha256_pkg::ST_PAD;
            end
            sha256_pkg::ST_PAD:   if (r_fill == 6'd63) n_st = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND: if (r_rnd == 6'd63) n_st = sha256_pkg::ST_FOLD;
            sha256_pkg::ST_FOLD: begin
                if (!r_final) n_st = sha256_pkg::ST_FILL;
                else if (r_second) n_st = sha256_pkg::ST_EMIT;
                else n_st = sha256_pkg::ST_PAD;
            end
            sha256_pkg::ST_EMIT:
                if (!i_stall && r_oidx == 3'd7) n_st = sha256_pkg::ST_FILL;
            default: n_st = sha256_pkg::ST_FILL;
        endcase
    end

    always_comb begin
        o_digest_word  = r_h[r_oidx];
        o_word_index   = r_oidx;
        o_last_word    = (r_oidx == 3'd7);
        o_length_error = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            sha256_pkg::ST_FILL: begin
                if (w_add) begin
                    r_w[r_fill[5:2]][8 * (3 - r_fill[1:0]) +: 8] <= i_req.data;
                end
                if (w_full_byte) begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
            end
            sha256_pkg::ST_PAD: begin
                r_w[r_fill[5:2]][8 * (3 - r_fill[1:0]) +: 8] <= w_pbyte;
                if (r_fill == 6'd63) begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
            end
            sha256_pkg::ST_ROUND: begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= r_w[0] + w_s0 + r_w[9] + w_s1;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
            default: ;
        endcase

        if (!i_rst_n) begin
            r_st       <= sha256_pkg::ST_FILL;
            r_fill     <= 6'd0;
            r_total    <= 64'd0;
            r_ovf      <= 1'b0;
            r_rnd      <= 6'd0;
            r_final    <= 1'b0;
            r_second   <= 1'b0;
            r_pad_head <= 1'b0;
            r_oidx     <= 3'd0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
        end else begin
            r_st <= n_st;
            case (r_st)
                sha256_pkg::ST_FILL: begin
                    if (w_take && i_req.valid && !w_add) r_ovf <= 1'b1;
                    if (w_add) r_total <= r_total + 64'd1;
                    r_rnd <= 6'd0;
                    if (w_full_byte) begin
                        r_fill     <= 6'd0;
                        r_final    <= i_req.last;
                        r_second   <= 1'b0;
                        r_pad_head <= i_req.last;
                    end else if (w_take && i_req.last) begin
                        // pad byte goes in at fill; then zeros / length
                        r_fill     <= w_ppos;
                        r_final    <= 1'b1;
                        r_second   <= (w_ppos < sha256_pkg::LEN_START);
                        r_pad_head <= 1'b1;
                    end else if (w_add) begin
                        r_fill <= r_fill + 6'd1;
                    end
                end
                sha256_pkg::ST_PAD: begin
                    r_fill     <= r_fill + 6'd1;
                    r_pad_head <= 1'b0;
                end
                sha256_pkg::ST_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                end
                sha256_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_rnd <= 6'd0;
                    if (r_final && !r_second) begin
                        // length goes in a fresh block
                        r_second <= 1'b1;
                        r_fill   <= 6'd0;
                    end
                end
                sha256_pkg::ST_EMIT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_fill   <= 6'd0;
                            r_total  <= 64'd0;
                            r_ovf    <= 1'b0;
                            r_final  <= 1'b0;
                            r_second <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[src/sha256_stream_hasher_core.sv]
// SHA-256 over a byte stream, one byte per request. A request with a byte is
// taken while a block fills; the 64th byte of a block starts a compression of
// 64 rounds plus one fold step, one round per cycle in a single round unit,
// during which new requests wait in a two-entry queue. A request with last
// pads (pad byte, zeros, bit length, one byte per cycle up to the block end),
// runs one or two compressions, then presents the digest as eight words, index 0
// first, all carrying the sticky length overflow flag; the hasher then returns
// to the initial hash values. A request with neither byte nor last is discarded.
module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_is_last,
    input  logic        i_valid,
    output logic        o_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_length_error,
    output logic        o_valid,
    input  logic        i_stall
);

    sha256_pkg::t_req w_req;
    logic             w_req_valid, w_req_pop;

    sha256_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_is_last    (i_is_last),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .o_req        (w_req),
        .o_req_valid  (w_req_valid),
        .i_req_pop    (w_req_pop)
    );

    sha256_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_req_valid    (w_req_valid),
        .o_req_pop      (w_req_pop),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word),
        .o_length_error (o_length_error),
        .o_valid        (o_valid),
        .i_stall        (i_stall)
    );

endmodule
